### design/mfhs_pkg.sv
package mfhs_pkg;

    localparam int COUNT_BITS_DEF = 24;

    localparam int SUM_BITS   = 33;
    localparam int BYTES_BITS = 36;

    // header field codes
    localparam logic [1:0] VBITS_MPEG1    = 2'b11;
    localparam logic [1:0] VBITS_MPEG2    = 2'b10;
    localparam logic [1:0] VBITS_RESERVED = 2'b01;
    localparam logic [1:0] LAYER_III      = 2'b01;
    localparam logic [3:0] BRI_FREE       = 4'd0;
    localparam logic [3:0] BRI_BAD        = 4'd15;
    localparam logic [1:0] SRI_RESERVED   = 2'd3;
    localparam logic [1:0] SRI_44K        = 2'd0;
    localparam logic [1:0] SRI_48K        = 2'd1;
    localparam logic [1:0] SRI_32K        = 2'd2;
    localparam logic [1:0] MODE_MONO      = 2'b11;

    // decoded version codes
    localparam logic [1:0] VER_NONE    = 2'd0;
    localparam logic [1:0] VER_MPEG1   = 2'd1;
    localparam logic [1:0] VER_MPEG2   = 2'd2;
    localparam logic [1:0] VER_MPEG25  = 2'd3;

    // info tag hint codes
    localparam logic [1:0] TAG_INFO = 2'd1;
    localparam logic [1:0] TAG_VBRI = 2'd2;

    // side-info tag offsets (slot offset minus the header)
    localparam logic [5:0] OFF_V1_MONO   = 6'(8'h15 - 8'd4);
    localparam logic [5:0] OFF_V1_STEREO = 6'(8'h24 - 8'd4);
    localparam logic [5:0] OFF_V2_MONO   = 6'(8'h0D - 8'd4);
    localparam logic [5:0] OFF_V2_STEREO = 6'(8'h15 - 8'd4);

    typedef enum logic [1:0] {
        STATUS_NONE,
        STATUS_COUNTED,
        STATUS_INFO_SKIP,
        STATUS_VBRI_REJECT
    } status_t;

    typedef struct packed {
        logic [31:0] header;
        logic [1:0]  info_tag;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  mpeg_version;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic [10:0] frame_bytes;
        logic        is_mono;
        logic [5:0]  tag_offset;
        logic [23:0] frame_count;
        logic        is_vbr;
        logic [2:0]  changes;
        logic [32:0] total_kbps;
        logic [35:0] output_bytes;
    } out_t;

    // one header after decode
    typedef struct packed {
        logic        valid;
        logic [1:0]  ver;
        logic [3:0]  bri;
        logic [1:0]  sri;
        logic        mono;
        logic [8:0]  kbps;
        logic [15:0] rate;
        logic [10:0] fbytes;
        logic [5:0]  off;
    } dec_t;

    // layer III bitrate rows: MPEG1, and MPEG2/2.5
    function automatic logic [8:0] kbps_lookup(input logic low_row, input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd1:    v = low_row ? 9'd8   : 9'd32;
            4'd2:    v = low_row ? 9'd16  : 9'd40;
            4'd3:    v = low_row ? 9'd24  : 9'd48;
            4'd4:    v = low_row ? 9'd32  : 9'd56;
            4'd5:    v = low_row ? 9'd40  : 9'd64;
            4'd6:    v = low_row ? 9'd48  : 9'd80;
            4'd7:    v = low_row ? 9'd56  : 9'd96;
            4'd8:    v = low_row ? 9'd64  : 9'd112;
            4'd9:    v = low_row ? 9'd80  : 9'd128;
            4'd10:   v = low_row ? 9'd96  : 9'd160;
            4'd11:   v = low_row ? 9'd112 : 9'd192;
            4'd12:   v = low_row ? 9'd128 : 9'd224;
            4'd13:   v = low_row ? 9'd144 : 9'd256;
            4'd14:   v = low_row ? 9'd160 : 9'd320;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sri);
        logic [15:0] v;
        case ({ver, sri})
            {VER_MPEG1, SRI_44K}:  v = 16'd44100;
            {VER_MPEG1, SRI_48K}:  v = 16'd48000;
            {VER_MPEG1, SRI_32K}:  v = 16'd32000;
            {VER_MPEG2, SRI_44K}:  v = 16'd22050;
            {VER_MPEG2, SRI_48K}:  v = 16'd24000;
            {VER_MPEG2, SRI_32K}:  v = 16'd16000;
            {VER_MPEG25, SRI_44K}: v = 16'd11025;
            {VER_MPEG25, SRI_48K}: v = 16'd12000;
            {VER_MPEG25, SRI_32K}: v = 16'd8000;
            default:               v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

### design/mfhs_decode.sv
module mfhs_decode (
    input  logic [31:0]       header,
    output mfhs_pkg::dec_t    dec
);
    import mfhs_pkg::*;

    // floor(x/49) for x <= 51200 as a reciprocal multiply
    localparam int          RECIP_SHIFT = 22;
    localparam logic [16:0] RECIP_49    = 17'(((1 << RECIP_SHIFT) + 48) / 49);

    logic [1:0]  vbits;
    logic [1:0]  layer;
    logic [3:0]  bri;
    logic [1:0]  sri;
    logic        pad;
    logic        ok;
    logic [1:0]  ver;
    logic        mono;
    logic [8:0]  kbps;
    logic [15:0] num49;
    logic [32:0] prod;
    logic [11:0] three_k;
    logic [11:0] nine_k;
    logic [10:0] quot;

    assign vbits = header[20:19];
    assign layer = header[18:17];
    assign bri   = header[15:12];
    assign sri   = header[11:10];
    assign pad   = header[9];

    assign ok = (&header[31:21]) && (vbits != VBITS_RESERVED) && (layer == LAYER_III)
                && (bri != BRI_FREE) && (bri != BRI_BAD) && (sri != SRI_RESERVED);

    always_comb begin
        case (vbits)
            VBITS_MPEG1: ver = VER_MPEG1;
            VBITS_MPEG2: ver = VER_MPEG2;
            default:     ver = VER_MPEG25;
        endcase
    end

    assign mono = (header[7:6] == MODE_MONO);
    assign kbps = kbps_lookup(ver != VER_MPEG1, bri);

    // K*1000/rate reduces to 160/49 or 320/49, 3 or 6, 9/2 or 9
    assign num49   = (ver == VER_MPEG25) ? 16'(kbps) * 16'd320 : 16'(kbps) * 16'd160;
    assign prod    = 33'(num49) * 33'(RECIP_49);
    assign three_k = 12'(kbps) * 12'd3;
    assign nine_k  = 12'(kbps) * 12'd9;

    always_comb begin
        case (sri)
            SRI_44K: quot = prod[RECIP_SHIFT +: 11];
            SRI_48K: quot = (ver == VER_MPEG25) ? {three_k[9:0], 1'b0} : three_k[10:0];
            default: quot = (ver == VER_MPEG25) ? nine_k[10:0] : nine_k[11:1];
        endcase
    end

    always_comb begin
        dec = '0;
        if (ok) begin
            dec.valid  = 1'b1;
            dec.ver    = ver;
            dec.bri    = bri;
            dec.sri    = sri;
            dec.mono   = mono;
            dec.kbps   = kbps;
            dec.rate   = rate_lookup(ver, sri);
            dec.fbytes = quot + 11'(pad);
            if (ver == VER_MPEG1) begin
                dec.off = mono ? OFF_V1_MONO : OFF_V1_STEREO;
            end else begin
                dec.off = mono ? OFF_V2_MONO : OFF_V2_STEREO;
            end
        end
    end

endmodule

### design/mp3_frame_header_scanner.sv
// MPEG audio layer III frame header scanner
//
// s_ channel: one request carries a 32-bit candidate header (first byte in
// bits 31..24) and the info tag hint found at the side-info slot.
// m_ channel: one result per request with the decoded header, a status code
// and the running totals (frame count, bitrate sum, projected output bytes,
// sticky vbr flag and per-frame change flags).
//
// A request passes an input register, then the decode and counter update,
// then the result register. One request per cycle is sustained while m_ready
// is high; the decode uses one reciprocal multiplier for the /49 case.
// When the receiver stalls, the result register holds and the input
// register keeps one more request, after which s_ready drops.
// Synchronous active-low reset empties both registers and clears all
// counters and reference values; the counters saturate instead of wrapping.
module mp3_frame_header_scanner #(
    parameter int COUNT_BITS = mfhs_pkg::COUNT_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mfhs_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output mfhs_pkg::out_t  m_data
);
    import mfhs_pkg::*;

    logic                   in_valid_reg;
    in_t                    in_data_reg;
    logic                   out_valid_reg;
    out_t                   out_data_reg;
    out_t                   out_data_next;

    logic [3:0]             first_rate_reg;
    logic                   first_seen_reg;
    logic                   vbr_reg;
    logic [COUNT_BITS-1:0]  frames_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [BYTES_BITS-1:0]  bytes_reg;
    logic [1:0]             ref_ver_reg;
    logic [1:0]             ref_sri_reg;
    logic                   ref_mono_reg;
    logic                   refs_valid_reg;

    logic [3:0]             first_rate_next;
    logic                   vbr_next;
    logic [COUNT_BITS-1:0]  frames_next;
    logic [SUM_BITS-1:0]    sum_next;
    logic [BYTES_BITS-1:0]  bytes_next;

    dec_t                   dec;
    logic                   advance;
    logic                   counted;
    status_t                status;
    logic [2:0]             chg;
    logic [SUM_BITS:0]      sum_wide;
    logic [11:0]            bytes_add;
    logic [BYTES_BITS:0]    bytes_wide;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    mfhs_decode u_decode (
        .header (in_data_reg.header),
        .dec    (dec)
    );

    always_comb begin
        if (!dec.valid) begin
            status = STATUS_NONE;
        end else if (in_data_reg.info_tag == TAG_INFO) begin
            status = STATUS_INFO_SKIP;
        end else if (in_data_reg.info_tag == TAG_VBRI) begin
            status = STATUS_VBRI_REJECT;
        end else begin
            status = STATUS_COUNTED;
        end
    end

    assign counted = (status == STATUS_COUNTED);

    // state after a counted frame
    always_comb begin
        first_rate_next = first_seen_reg ? first_rate_reg : dec.bri;
        vbr_next        = vbr_reg || (first_rate_next != dec.bri);
        frames_next     = (&frames_reg) ? frames_reg : frames_reg + 1'b1;
        sum_wide        = {1'b0, sum_reg} + (SUM_BITS + 1)'(dec.kbps);
        sum_next        = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
        // first frame counts twice to reserve room for the header frame
        bytes_add       = (frames_reg == '0) ? {dec.fbytes, 1'b0} : {1'b0, dec.fbytes};
        bytes_wide      = {1'b0, bytes_reg} + (BYTES_BITS + 1)'(bytes_add);
        bytes_next      = bytes_wide[BYTES_BITS] ? '1 : bytes_wide[BYTES_BITS-1:0];
        chg             = '0;
        if (refs_valid_reg) begin
            chg = {ref_mono_reg != dec.mono, ref_sri_reg != dec.sri, ref_ver_reg != dec.ver};
        end
    end

    always_comb begin
        out_data_next                = '0;
        out_data_next.status         = status;
        out_data_next.mpeg_version   = dec.ver;
        out_data_next.bitrate_kbps   = dec.kbps;
        out_data_next.sample_rate_hz = dec.rate;
        out_data_next.frame_bytes    = dec.fbytes;
        out_data_next.is_mono        = dec.mono;
        out_data_next.tag_offset     = dec.off;
        if (counted) begin
            out_data_next.frame_count  = 24'(frames_next);
            out_data_next.is_vbr       = vbr_next;
            out_data_next.changes      = chg;
            out_data_next.total_kbps   = sum_next;
            out_data_next.output_bytes = bytes_next;
        end else begin
            out_data_next.frame_count  = 24'(frames_reg);
            out_data_next.is_vbr       = vbr_reg;
            out_data_next.changes      = '0;
            out_data_next.total_kbps   = sum_reg;
            out_data_next.output_bytes = bytes_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_rate_reg <= '0;
            first_seen_reg <= 1'b0;
            vbr_reg        <= 1'b0;
            frames_reg     <= '0;
            sum_reg        <= '0;
            bytes_reg      <= '0;
            ref_ver_reg    <= '0;
            ref_sri_reg    <= '0;
            ref_mono_reg   <= 1'b0;
            refs_valid_reg <= 1'b0;
        end else if (advance && counted) begin
            first_rate_reg <= first_rate_next;
            first_seen_reg <= 1'b1;
            vbr_reg        <= vbr_next;
            frames_reg     <= frames_next;
            sum_reg        <= sum_next;
            bytes_reg      <= bytes_next;
            ref_ver_reg    <= dec.ver;
            ref_sri_reg    <= dec.sri;
            ref_mono_reg   <= dec.mono;
            refs_valid_reg <= 1'b1;
        end
    end

    a_frames_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> frames_reg >= $past(frames_reg))
        else $error("frame counter went backwards");

    a_vbr_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        vbr_reg |=> vbr_reg)
        else $error("vbr flag cleared without reset");

    a_counted_has_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.status == STATUS_COUNTED) |-> frames_reg != '0)
        else $error("counted frame reported with zero frame count");

    a_stall_holds_totals: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> $stable(sum_reg) && $stable(bytes_reg))
        else $error("totals moved while the pipeline was stalled");

endmodule

### bench/mfhs_checker.sv
`timescale 1ns / 1ps

module mfhs_checker #(
    parameter int COUNT_BITS = mfhs_pkg::COUNT_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  mfhs_pkg::in_t   s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  mfhs_pkg::out_t  m_data,
    output int              mismatches,
    output int              pending
);

    import mfhs_pkg::*;

    localparam longint unsigned FRAMES_MAX = (longint'(1) << COUNT_BITS) - 1;
    localparam longint unsigned KBPS_MAX   = (longint'(1) << SUM_BITS) - 1;
    localparam longint unsigned BYTES_MAX  = (longint'(1) << BYTES_BITS) - 1;

    // layer III bitrates: MPEG1 row, then the shared MPEG2 / MPEG2.5 row
    int unsigned kbps_v1 [0:15] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192,
                                    224, 256, 320, 0};
    int unsigned kbps_v2 [0:15] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112,
                                    128, 144, 160, 0};
    int unsigned hz_v1  [0:2] = '{44100, 48000, 32000};
    int unsigned hz_v2  [0:2] = '{22050, 24000, 16000};
    int unsigned hz_v25 [0:2] = '{11025, 12000, 8000};

    logic [3:0]      first_bri;
    logic            first_bri_seen;
    logic            vbr_flag;
    longint unsigned frames_total;
    longint unsigned kbps_total;
    longint unsigned bytes_total;
    logic [1:0]      last_ver;
    logic [1:0]      last_sri;
    logic            last_mono;
    logic            last_valid;

    out_t awaited_results [$];

    function automatic longint unsigned sat_add(input longint unsigned a,
                                                input longint unsigned b,
                                                input longint unsigned lim);
        return (b >= lim || a > lim - b) ? lim : a + b;
    endfunction

    task automatic decode_and_tally(input in_t req, output out_t res);
        logic [31:0] h;
        logic [1:0]  vbits;
        logic [3:0]  bri;
        logic [1:0]  sri;
        logic [1:0]  ver;
        logic        mono;
        int unsigned kbps;
        int unsigned hz;
        int unsigned fbytes;
        logic [2:0]  chg;
        h     = req.header;
        vbits = h[20:19];
        bri   = h[15:12];
        sri   = h[11:10];
        chg   = 3'b000;
        res   = '0;
        res.status = STATUS_NONE;
        if (&h[31:21] && vbits != VBITS_RESERVED && h[18:17] == LAYER_III &&
            bri != BRI_FREE && bri != BRI_BAD && sri != SRI_RESERVED) begin
            ver  = (vbits == VBITS_MPEG1) ? VER_MPEG1 :
                   (vbits == VBITS_MPEG2) ? VER_MPEG2 : VER_MPEG25;
            mono = (h[7:6] == MODE_MONO);
            kbps = (ver == VER_MPEG1) ? kbps_v1[bri] : kbps_v2[bri];
            case (ver)
                VER_MPEG1: hz = hz_v1[sri];
                VER_MPEG2: hz = hz_v2[sri];
                default:   hz = hz_v25[sri];
            endcase
            fbytes = ((ver == VER_MPEG1 ? 144000 : 72000) * kbps) / hz + h[9];

            res.mpeg_version   = ver;
            res.bitrate_kbps   = 9'(kbps);
            res.sample_rate_hz = 16'(hz);
            res.frame_bytes    = 11'(fbytes);
            res.is_mono        = mono;
            if (ver == VER_MPEG1)
                res.tag_offset = mono ? OFF_V1_MONO : OFF_V1_STEREO;
            else
                res.tag_offset = mono ? OFF_V2_MONO : OFF_V2_STEREO;

            if (req.info_tag == TAG_INFO) begin
                res.status = STATUS_INFO_SKIP;
            end else if (req.info_tag == TAG_VBRI) begin
                res.status = STATUS_VBRI_REJECT;
            end else begin
                res.status = STATUS_COUNTED;
                if (!first_bri_seen) begin
                    first_bri_seen = 1'b1;
                    first_bri      = bri;
                end
                if (first_bri != bri)
                    vbr_flag = 1'b1;
                kbps_total = sat_add(kbps_total, kbps, KBPS_MAX);
                // first counted frame reserves room for the header frame
                if (frames_total == 0)
                    bytes_total = sat_add(bytes_total, fbytes, BYTES_MAX);
                bytes_total = sat_add(bytes_total, fbytes, BYTES_MAX);
                if (frames_total < FRAMES_MAX)
                    frames_total++;
                if (!last_valid) begin
                    last_valid = 1'b1;
                    last_ver   = ver;
                    last_sri   = sri;
                    last_mono  = mono;
                end
                if (last_ver != ver) begin
                    chg[0]   = 1'b1;
                    last_ver = ver;
                end
                if (last_sri != sri) begin
                    chg[1]   = 1'b1;
                    last_sri = sri;
                end
                if (last_mono != mono) begin
                    chg[2]    = 1'b1;
                    last_mono = mono;
                end
            end
        end
        res.changes      = chg;
        res.frame_count  = 24'(frames_total);
        res.is_vbr       = vbr_flag;
        res.total_kbps   = 33'(kbps_total);
        res.output_bytes = 36'(bytes_total);
    endtask

    task automatic check_field(input string name, input logic [35:0] want,
                               input logic [35:0] got, inout bit bad);
        if (want !== got) begin
            bad = 1'b1;
            if (mismatches < 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    task automatic compare_result(input out_t want, input out_t got);
        bit bad;
        bad = 1'b0;
        check_field("status", want.status, got.status, bad);
        check_field("mpeg_version", want.mpeg_version, got.mpeg_version, bad);
        check_field("bitrate_kbps", want.bitrate_kbps, got.bitrate_kbps, bad);
        check_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz, bad);
        check_field("frame_bytes", want.frame_bytes, got.frame_bytes, bad);
        check_field("is_mono", want.is_mono, got.is_mono, bad);
        check_field("tag_offset", want.tag_offset, got.tag_offset, bad);
        check_field("frame_count", want.frame_count, got.frame_count, bad);
        check_field("is_vbr", want.is_vbr, got.is_vbr, bad);
        check_field("changes", want.changes, got.changes, bad);
        check_field("total_kbps", want.total_kbps, got.total_kbps, bad);
        check_field("output_bytes", want.output_bytes, got.output_bytes, bad);
        if (bad)
            mismatches++;
    endtask

    always @(posedge aclk) begin : monitor
        out_t want;
        if (!aresetn) begin
            first_bri      = '0;
            first_bri_seen = 1'b0;
            vbr_flag       = 1'b0;
            frames_total   = 0;
            kbps_total     = 0;
            bytes_total    = 0;
            last_ver       = '0;
            last_sri       = '0;
            last_mono      = 1'b0;
            last_valid     = 1'b0;
            awaited_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with no request outstanding", $realtime);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_result(want, m_data);
                end
            end
            if (s_valid && s_ready) begin
                decode_and_tally(s_data, want);
                awaited_results.push_back(want);
            end
        end
        pending = awaited_results.size();
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import mfhs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_HOLD = 300;

    localparam logic [1:0] VBITS_MPEG25   = 2'b00;
    localparam logic [1:0] LAYER_RESERVED = 2'b00;
    localparam logic [1:0] LAYER_II       = 2'b10;
    localparam logic [1:0] LAYER_I        = 2'b11;
    localparam logic [1:0] MODE_STEREO    = 2'b00;
    localparam logic [1:0] TAG_NONE       = 2'd0;
    localparam logic [1:0] TAG_UNKNOWN    = 2'd3;

    typedef enum logic [2:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } phase_t;

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    in_t    s_data  = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    out_t   m_data;
    int     mismatches;
    int     pending;
    int     cycle_count = 0;
    phase_t phase = PH_FREE;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    mp3_frame_header_scanner i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    mfhs_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic int sender_idle_pct(input phase_t p);
        return (p == PH_SEND_IDLE) ? 49 : (p == PH_BOTH) ? 30 : 0;
    endfunction

    function automatic int receiver_stall_pct(input phase_t p);
        return (p == PH_RECV_STALL) ? 49 : (p == PH_BOTH) ? 30 : 0;
    endfunction

    function automatic logic [31:0] make_header(input logic [1:0] vbits, input logic [1:0] layer,
                                                input logic [3:0] bri, input logic [1:0] sri,
                                                input logic pad, input logic [1:0] mode);
        return {11'h7FF, vbits, layer, 1'b1, bri, sri, pad, 1'b0, mode, 6'b0};
    endfunction

    // mostly well-formed headers with random content, some noise and broken fields
    function automatic in_t random_request();
        in_t         req;
        logic [31:0] h;
        int          pick;
        int          tag_pick;
        h    = $urandom();
        pick = $urandom_range(99);
        if (pick >= 8) begin
            h[31:21] = '1;
            h[18:17] = LAYER_III;
            case ($urandom_range(2))
                0:       h[20:19] = VBITS_MPEG1;
                1:       h[20:19] = VBITS_MPEG2;
                default: h[20:19] = VBITS_MPEG25;
            endcase
            h[15:12] = 4'($urandom_range(14, 1));
            h[11:10] = 2'($urandom_range(2));
            if (pick < 20) begin
                case ($urandom_range(4))
                    0: h[31 - $urandom_range(10)] = 1'b0;
                    1: h[20:19] = VBITS_RESERVED;
                    2: begin
                        case ($urandom_range(2))
                            0:       h[18:17] = LAYER_RESERVED;
                            1:       h[18:17] = LAYER_II;
                            default: h[18:17] = LAYER_I;
                        endcase
                    end
                    3: h[15:12] = $urandom_range(1) ? BRI_FREE : BRI_BAD;
                    default: h[11:10] = SRI_RESERVED;
                endcase
            end
        end
        tag_pick = $urandom_range(99);
        req.header   = h;
        req.info_tag = (tag_pick < 70) ? TAG_NONE : (tag_pick < 80) ? TAG_INFO :
                       (tag_pick < 90) ? TAG_VBRI : TAG_UNKNOWN;
        return req;
    endfunction

    task automatic send_request(input logic [31:0] hdr, input logic [1:0] tag);
        in_t req;
        req.header   = hdr;
        req.info_tag = tag;
        if ($urandom_range(99) < sender_idle_pct(phase)) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct(phase));
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic run_phase(input phase_t p, input int count);
        in_t req;
        phase = p;
        repeat (count) begin
            req = random_request();
            send_request(req.header, req.info_tag);
        end
    endtask

    initial begin : result_receiver
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            // one long hold-off so the block fills and pushes back on requests
            if (phase == PH_PRESSURE && !held) begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct(phase));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first frame, extremes of each bitrate table, tag handling, rejects
        send_request(make_header(VBITS_MPEG1, LAYER_III, 4'd9, SRI_44K, 1'b0, MODE_STEREO),
                     TAG_NONE);
        send_request(make_header(VBITS_MPEG1, LAYER_III, 4'd9, SRI_44K, 1'b0, MODE_STEREO),
                     TAG_UNKNOWN);
        send_request(make_header(VBITS_MPEG1, LAYER_III, 4'd14, SRI_32K, 1'b1, MODE_MONO),
                     TAG_NONE);
        send_request(make_header(VBITS_MPEG2, LAYER_III, 4'd1, SRI_48K, 1'b0, MODE_MONO),
                     TAG_NONE);
        send_request(make_header(VBITS_MPEG25, LAYER_III, 4'd14, SRI_32K, 1'b1, MODE_STEREO),
                     TAG_NONE);
        send_request(make_header(VBITS_MPEG25, LAYER_III, 4'd1, SRI_32K, 1'b0, MODE_MONO),
                     TAG_INFO);
        send_request(make_header(VBITS_MPEG1, LAYER_III, 4'd5, SRI_48K, 1'b1, MODE_STEREO),
                     TAG_VBRI);
        send_request(32'h0000_0000, TAG_NONE);
        send_request(32'hFFFF_FFFF, TAG_NONE);
        send_request(make_header(VBITS_MPEG1, LAYER_III, 4'd9, SRI_44K, 1'b0, MODE_STEREO)
                     & ~32'h0020_0000, TAG_NONE);
        send_request(make_header(VBITS_RESERVED, LAYER_III, 4'd9, SRI_44K, 1'b0, MODE_STEREO),
                     TAG_NONE);
        send_request(make_header(VBITS_MPEG1, LAYER_RESERVED, 4'd9, SRI_44K, 1'b0, MODE_STEREO),
                     TAG_NONE);
        send_request(make_header(VBITS_MPEG1, LAYER_II, 4'd9, SRI_44K, 1'b0, MODE_STEREO),
                     TAG_NONE);
        send_request(make_header(VBITS_MPEG2, LAYER_I, 4'd9, SRI_44K, 1'b0, MODE_STEREO),
                     TAG_NONE);
        send_request(make_header(VBITS_MPEG1, LAYER_III, BRI_FREE, SRI_44K, 1'b0, MODE_STEREO),
                     TAG_NONE);
        send_request(make_header(VBITS_MPEG1, LAYER_III, BRI_BAD, SRI_44K, 1'b0, MODE_STEREO),
                     TAG_NONE);
        send_request(make_header(VBITS_MPEG1, LAYER_III, 4'd9, SRI_RESERVED, 1'b0, MODE_STEREO),
                     TAG_NONE);
        send_request(make_header(VBITS_MPEG2, LAYER_III, 4'd8, SRI_44K, 1'b1, MODE_MONO),
                     TAG_UNKNOWN);
        send_request(make_header(VBITS_MPEG1, LAYER_III, 4'd1, SRI_48K, 1'b1, MODE_STEREO),
                     TAG_NONE);
        send_request(make_header(VBITS_MPEG25, LAYER_III, 4'd7, SRI_44K, 1'b0, MODE_MONO),
                     TAG_NONE);

        run_phase(PH_FREE, 80);
        run_phase(PH_SEND_IDLE, 80);
        run_phase(PH_RECV_STALL, 80);
        run_phase(PH_BOTH, 80);
        run_phase(PH_PRESSURE, 60);
        phase = PH_FREE;
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
